>>> rtl/llg_pkg.sv
// Package with payload types and constants for the log loss block.
package llg_pkg;

	localparam int unsigned MaxPositions = 1048576;
	localparam logic [16:0] OneQ16 = 17'd65536;
	localparam logic [31:0] Ln2Q32 = 32'd2977044472;
	localparam logic [43:0] SumMax = {44{1'b1}};
	localparam logic [19:0] AvgMax = {20{1'b1}};
	localparam logic [40:0] GradMagMax = 41'd1 << 40;

	localparam logic [0:0] RegThreshold = 1'b0;
	localparam logic [0:0] RegTotal = 1'b1;

	typedef struct packed {
		logic [16:0] prob;
		logic [7:0] label;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic signed [40:0] gradient;
		logic [7:0] grad_channel;
		logic [19:0] avg_loss;
		logic loss_valid;
	} out_item_t;

	// Classified item handed from the front end to the back end.
	typedef struct packed {
		logic [16:0] p;
		logic [20:0] tot;
		logic [7:0] label;
		logic last;
	} work_t;

endpackage

>>> rtl/log_loss_with_gradient_core.sv
// Top level of the streaming negative log likelihood loss with gradient.
// Each transfer in yields one transfer out with the gradient -1/(total*p) and, on the last item
// of a batch, the average loss. In the back end an item takes 24 squaring steps of the log2
// mantissa, then a 45-step restoring divider that is used once for the reciprocal and, on a
// last item, once more for the average; the result then waits while out_stall is high.
// A two-entry queue lets the front end accept items while the back end works or its result waits.
module log_loss_with_gradient_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input llg_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output llg_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [20:0] cfg_data
);
	import llg_pkg::*;

	logic [16:0] thr_q;
	logic [20:0] tot_q;
	logic q_valid, q_pop;
	work_t q_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 17'd1;
			tot_q <= 21'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegThreshold: thr_q <= cfg_data[16:0];
				RegTotal: tot_q <= cfg_data;
				default: ;
			endcase
		end
	end

	llg_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.thr(thr_q), .tot(tot_q), .q_valid, .q_pop, .q_data
	);

	llg_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_data, .out_valid, .out_stall, .out_data
	);
endmodule

>>> rtl/llg_front.sv
// Front end: clamps the probability and total and queues the work item.
module llg_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input llg_pkg::in_item_t in_data,
	input logic [16:0] thr,
	input logic [20:0] tot,
	output logic q_valid,
	input logic q_pop,
	output llg_pkg::work_t q_data
);
	import llg_pkg::*;

	work_t fifo_q [2];
	logic [0:0] wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push;
	logic [16:0] thr_e, p_c;
	logic [20:0] tot_e;
	work_t w;

	// Clamp the probability to the threshold and to one, and the total to one up to MaxPositions.
	always_comb begin
		thr_e = (thr == 17'd0) ? 17'd1 : thr;
		tot_e = (tot == 21'd0) ? 21'd1 :
			(tot > 21'(MaxPositions)) ? 21'(MaxPositions) : tot;
		p_c = (in_data.prob < thr_e) ? thr_e : in_data.prob;
		if (p_c > OneQ16) p_c = OneQ16;
		w.p = p_c;
		w.tot = tot_e;
		w.label = in_data.label;
		w.last = in_data.last;
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= w;
	end

	// Two-entry queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue overflow");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
endmodule

>>> rtl/llg_back.sv
// Back end: iterative log, reciprocal and average division, one item at a time.
module llg_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_pop,
	input llg_pkg::work_t q_data,
	output logic out_valid,
	input logic out_stall,
	output llg_pkg::out_item_t out_data
);
	import llg_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_LOG  = 7'b0000010,
		S_MUL  = 7'b0000100,
		S_DIV  = 7'b0001000,
		S_AVG  = 7'b0010000,
		S_ADIV = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	work_t w_q;
	logic [43:0] sum_q;
	logic [32:0] x_q;
	logic [28:0] l2_q;
	logic [5:0] cnt_q;
	logic [37:0] d_q;
	logic [44:0] rem_q;
	logic [44:0] quo_q;
	logic [44:0] num_q;
	logic [40:0] grad_q;
	logic [65:0] xx;
	logic [32:0] xs;
	logic [4:0] e;
	logic [28:0] nl2;
	logic [60:0] prod;
	logic [44:0] rsh, sum_add;
	logic [45:0] rsub;

	// Top set bit of the clamped probability.
	always_comb begin
		e = 5'd0;
		for (int i = 1; i <= 16; i++) if (q_data.p[i]) e = 5'(i);
	end

	// One squaring step of the log2 mantissa.
	always_comb begin
		xx = 66'(x_q) * 66'(x_q);
		xs = 33'(xx >> 31);
	end

	assign nl2 = (29'd16 << 24) - l2_q;
	assign rsh = {rem_q[43:0], num_q[44]};
	assign rsub = {1'b0, rsh} - {8'd0, d_q};
	assign sum_add = {1'b0, sum_q} + {25'd0, prod[59:40]};

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (q_valid) begin
				w_q <= q_data;
				x_q <= 33'({16'd0, q_data.p} << (5'd31 - e));
				l2_q <= 29'(e) << 24;
			end
			S_LOG: begin
				if (xs[32]) begin
					x_q <= xs >> 1;
					l2_q[5'd23 - cnt_q[4:0]] <= 1'b1;
				end else x_q <= xs;
			end
			S_MUL: begin
				prod <= 61'(nl2) * 61'(Ln2Q32) + (61'd1 << 39);
				d_q <= 38'(w_q.tot) * 38'(w_q.p);
				num_q <= 45'd1 << 12;
				rem_q <= '0;
				quo_q <= '0;
			end
			S_DIV, S_ADIV: begin
				if (state_q == S_DIV && cnt_q == 6'd0) begin
					// Numerator is 2^32 ORed with d/2.
					num_q <= (45'(1) << 32) | 45'(d_q >> 1);
				end else begin
					num_q <= num_q << 1;
					if (!rsub[45]) begin
						rem_q <= rsub[44:0];
						quo_q <= {quo_q[43:0], 1'b1};
					end else begin
						rem_q <= rsh;
						quo_q <= {quo_q[43:0], 1'b0};
					end
				end
			end
			S_AVG: begin
				grad_q <= (quo_q > 45'(GradMagMax)) ? GradMagMax : quo_q[40:0];
				d_q <= 38'(w_q.tot);
				num_q <= 45'(sum_q) + 45'(w_q.tot >> 1);
				rem_q <= '0;
				quo_q <= '0;
			end
			S_OUT: ;
			default: ;
		endcase
	end

	// Sequencer and accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			sum_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (q_valid) begin
					state_q <= S_LOG;
					cnt_q <= '0;
				end
				S_LOG: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd23) state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_DIV;
					cnt_q <= '0;
				end
				S_DIV: begin
					if (cnt_q == 6'd0) sum_q <= sum_add[44] ? SumMax : sum_add[43:0];
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd45) state_q <= S_AVG;
				end
				S_AVG: begin
					cnt_q <= '0;
					state_q <= w_q.last ? S_ADIV : S_OUT;
				end
				S_ADIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd44) begin
						state_q <= S_OUT;
						sum_q <= '0;
					end
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result fields.
	always_comb begin
		out_data.gradient = -$signed(grad_q);
		out_data.grad_channel = w_q.label;
		out_data.loss_valid = w_q.last;
		out_data.avg_loss = !w_q.last ? 20'd0 :
			(quo_q > 45'(AvgMax)) ? AvgMax : quo_q[19:0];
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == S_LOG) else $error("pop outside idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(out_data)) else $error("result dropped");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADIV && cnt_q == 6'd44) |=> sum_q == 44'd0) else $error("sum not cleared");
endmodule
